// File: rtl/core/utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder.
// Both macros expect clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define U8SD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8_stream_decoder: check failed");
`define U8SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8_stream_decoder: check failed");
`else
`define U8SD_ASSERT_IMP(label, ante, cons)
`define U8SD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int CpW  = 21;
  localparam int AccW = 15;

  localparam logic [7:0] MASK_TOP1  = 8'h80;
  localparam logic [7:0] MASK_TOP2  = 8'hc0;
  localparam logic [7:0] MASK_TOP3  = 8'he0;
  localparam logic [7:0] MASK_TOP4  = 8'hf0;
  localparam logic [7:0] MASK_TOP5  = 8'hf8;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_TAG  = 8'hc0;
  localparam logic [7:0] LEAD3_TAG  = 8'he0;
  localparam logic [7:0] LEAD4_TAG  = 8'hf0;
  localparam logic [7:0] LEAD2_BITS = 8'h1f;
  localparam logic [7:0] LEAD3_BITS = 8'h0f;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_BITS  = 8'h3f;

  localparam logic [2:0] SEQ_IDLE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_error;
    logic           last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [1:0]     err_cnt;
    logic           has_tail;
    logic [CpW-1:0] tail_cp;
    logic           tail_err;
  } job_t;

  typedef struct packed {
    logic [1:0] held_cnt;
    logic [2:0] seq_len;
  } front_status_t;

endpackage

// File: rtl/core/utf8sd_front.sv
module utf8sd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  utf8sd_pkg::in_word_t      in_word,
  input  logic                      q_full,
  output logic                      push,
  output utf8sd_pkg::job_t          job,
  output utf8sd_pkg::front_status_t status
);
  import utf8sd_pkg::*;

  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic [2:0]      seq_len_r, seq_len_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic            accept;
  logic [7:0]      b;

  logic            f_tail;
  logic [CpW-1:0]  f_cp;
  logic            f_err;
  logic [1:0]      f_held;
  logic [2:0]      f_seq;
  logic [AccW-1:0] f_acc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_word.data_byte;
  assign status   = '{held_cnt: held_cnt_r, seq_len: seq_len_r};

  // classify a byte as if no sequence were pending
  always_comb begin
    f_tail = 1'b0;
    f_cp   = '0;
    f_err  = 1'b0;
    f_held = 2'd0;
    f_seq  = SEQ_IDLE;
    f_acc  = acc_r;
    if ((b & MASK_TOP1) == 8'h00) begin
      f_tail = 1'b1;
      f_cp   = {{(CpW-8){1'b0}}, b};
    end else if ((b & MASK_TOP3) == LEAD2_TAG) begin
      f_held = 2'd1;
      f_seq  = SEQ_TWO;
      f_acc  = {{(AccW-8){1'b0}}, b & LEAD2_BITS};
    end else if ((b & MASK_TOP4) == LEAD3_TAG) begin
      f_held = 2'd1;
      f_seq  = SEQ_THREE;
      f_acc  = {{(AccW-8){1'b0}}, b & LEAD3_BITS};
    end else if ((b & MASK_TOP5) == LEAD4_TAG) begin
      f_held = 2'd1;
      f_seq  = SEQ_FOUR;
      f_acc  = {{(AccW-8){1'b0}}, b & LEAD4_BITS};
    end else begin
      f_tail = 1'b1;
      f_err  = 1'b1;
    end
  end

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    seq_len_nxt  = seq_len_r;
    acc_nxt      = acc_r;
    job          = '0;
    if (in_word.end_of_text) begin
      job.err_cnt  = held_cnt_r;
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = SEQ_IDLE;
    end else if (held_cnt_r == 2'd0 || seq_len_r == SEQ_IDLE) begin
      job.has_tail = f_tail;
      job.tail_cp  = f_cp;
      job.tail_err = f_err;
      held_cnt_nxt = f_held;
      seq_len_nxt  = f_seq;
      acc_nxt      = f_acc;
    end else if ((b & MASK_TOP2) == CONT_TAG) begin
      if (({1'b0, held_cnt_r} + 3'd1) >= seq_len_r) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {acc_r, b[5:0] & CONT_BITS[5:0]};
        held_cnt_nxt = 2'd0;
        seq_len_nxt  = SEQ_IDLE;
      end else begin
        acc_nxt      = {acc_r[AccW-7:0], b[5:0] & CONT_BITS[5:0]};
        held_cnt_nxt = held_cnt_r + 2'd1;
      end
    end else begin
      job.err_cnt  = held_cnt_r;
      job.has_tail = f_tail;
      job.tail_cp  = f_cp;
      job.tail_err = f_err;
      held_cnt_nxt = f_held;
      seq_len_nxt  = f_seq;
      acc_nxt      = f_acc;
    end
  end

  assign push = accept && (job.err_cnt != 2'd0 || job.has_tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seq_len_r  <= SEQ_IDLE;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      seq_len_r  <= seq_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: rtl/core/utf8sd_queue.sv
module utf8sd_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  utf8sd_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output utf8sd_pkg::job_t head_job
);
  import utf8sd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/utf8sd_back.sv
module utf8sd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  utf8sd_pkg::job_t      head_job,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8sd_pkg::out_word_t out_word
);
  import utf8sd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic [1:0] sent_r, sent_nxt;
  logic      load;
  logic      job_done;

  assign load = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_word_nxt = '0;
    job_done     = 1'b0;
    if (sent_r < head_job.err_cnt) begin
      out_word_nxt.is_error    = 1'b1;
      job_done                 = ((sent_r + 2'd1) == head_job.err_cnt) && !head_job.has_tail;
      out_word_nxt.last_of_run = job_done;
    end else begin
      out_word_nxt.code_point  = head_job.tail_cp;
      out_word_nxt.is_error    = head_job.tail_err;
      out_word_nxt.last_of_run = 1'b1;
      job_done                 = 1'b1;
    end
  end

  assign pop = load && job_done;

  always_comb begin
    sent_nxt = sent_r;
    if (pop) begin
      sent_nxt = 2'd0;
    end else if (load) begin
      sent_nxt = sent_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder. One byte word is taken per cycle while in_ready is high; each byte
// gives zero to four result words (code points or per-byte errors, the final one of each
// byte flagged last_of_run), and the output port delivers one result word per cycle while
// out_ready is high. A queue of QUEUE_DEPTH pending byte jobs between the byte classifier
// and the result expander lets input keep flowing meanwhile, so in_ready drops only when
// that queue is full. A byte's first result passes a queue slot, then the output register.
// No overlong or surrogate checks are made and leads F0-F7 are accepted.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8sd_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8sd_pkg::out_word_t out_word
);
  import utf8sd_pkg::*;

  logic          q_full;
  logic          q_push;
  job_t          q_push_job;
  logic          q_pop;
  logic          q_head_valid;
  job_t          q_head_job;
  front_status_t fr_status;
  logic          pend_ok;

  utf8sd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .push     (q_push),
    .job      (q_push_job),
    .status   (fr_status)
  );

  utf8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  utf8sd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  assign pend_ok = ({1'b0, fr_status.held_cnt} < fr_status.seq_len) &&
                   (fr_status.seq_len >= SEQ_TWO) && (fr_status.seq_len <= SEQ_FOUR);

  `U8SD_ASSERT_IMP(a_err_zero_cp, out_valid && out_word.is_error, out_word.code_point == '0)
  `U8SD_ASSERT_IMP(a_pending_len, fr_status.held_cnt != 2'd0, pend_ok)
  `U8SD_ASSERT_NEXT(a_push_visible, q_push, q_head_valid)
  `U8SD_ASSERT_IMP(a_no_overflow, q_full, !q_push)

endmodule
